// ===== hdl/aesbcm_pkg.sv =====
// Shared types, codes, constants and AES round functions for the AES modes core.
// No dependencies; the front end, back end and top level import this package.
package aesbcm_pkg;

    localparam int COLUMNS     = 4;
    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_W     = 8 * BLOCK_BYTES;
    localparam int KEY_W       = 256;
    localparam int RK_ROWS     = 16;

    localparam logic [63:0] NONCE_HI = 64'h0001020304050607;

    localparam logic [3:0] NR_128 = 4'd10;
    localparam logic [3:0] NR_192 = 4'd12;
    localparam logic [3:0] NR_256 = 4'd14;
    localparam logic [3:0] NK_128 = 4'd4;
    localparam logic [3:0] NK_192 = 4'd6;
    localparam logic [3:0] NK_256 = 4'd8;

    localparam logic [1:0] KSZ_128 = 2'd0;
    localparam logic [1:0] KSZ_192 = 2'd1;

    localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
    localparam logic [2:0] CFG_MODE     = 3'd1;
    localparam logic [2:0] CFG_SEGMENT  = 3'd2;
    localparam logic [2:0] CFG_KEY_W0   = 3'd3;
    localparam logic [2:0] CFG_KEY_W3   = 3'd6;

    localparam logic [3:0] MODE_ECB_ENC = 4'd0;
    localparam logic [3:0] MODE_ECB_DEC = 4'd1;
    localparam logic [3:0] MODE_CBC_ENC = 4'd2;
    localparam logic [3:0] MODE_CBC_DEC = 4'd3;
    localparam logic [3:0] MODE_CFB_ENC = 4'd4;
    localparam logic [3:0] MODE_CFB_DEC = 4'd5;
    localparam logic [3:0] MODE_OFB_ENC = 4'd6;
    localparam logic [3:0] MODE_OFB_DEC = 4'd7;
    localparam logic [3:0] MODE_CTR     = 4'd8;

    localparam logic REQ_DATA = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD_IV = 2'd0,
        OP_CTR_RST = 2'd1,
        OP_DATA    = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]       key_size;
        logic [3:0]       mode;
        logic [4:0]       segment;
        logic [KEY_W-1:0] key;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [BLOCK_W-1:0] data;
    } q_entry_t;

    typedef struct packed {
        logic       in_round;
        logic       keys_ready;
        logic [3:0] rnd;
        logic [3:0] nr;
    } core_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte k of a block sits in bits [127-8k -: 8]
    function automatic logic [BLOCK_W-1:0] sub_bytes(input logic [BLOCK_W-1:0] b, input logic inv);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            t[BLOCK_W-1-8*k -: 8] = inv ? INV_SBOX[b[BLOCK_W-1-8*k -: 8]]
                                        : SBOX[b[BLOCK_W-1-8*k -: 8]];
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] b, input logic inv);
        logic [BLOCK_W-1:0] t;
        int src;
        t = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? (((c + 4 - r) % 4) * 4 + r) : (((c + r) % 4) * 4 + r);
                t[BLOCK_W-1-8*(c*4+r) -: 8] = b[BLOCK_W-1-8*src -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] b, input logic inv);
        logic [BLOCK_W-1:0] t;
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [7:0] f0 [4];
        logic [7:0] f1 [4];
        logic [7:0] f2 [4];
        logic [7:0] f3 [4];
        t = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = b[BLOCK_W-1-8*(c*4+r) -: 8];
                m2[r] = xt(a[r]);
                m4[r] = xt(m2[r]);
                m8[r] = xt(m4[r]);
                // f0..f3 are the products by the matrix's four coefficients
                f0[r] = inv ? (m8[r] ^ m4[r] ^ m2[r]) : m2[r];
                f1[r] = inv ? (m8[r] ^ m2[r] ^ a[r]) : (m2[r] ^ a[r]);
                f2[r] = inv ? (m8[r] ^ m4[r] ^ a[r]) : a[r];
                f3[r] = inv ? (m8[r] ^ a[r]) : a[r];
            end
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(c*4+r) -: 8] = f0[r] ^ f1[(r+1)%4] ^ f2[(r+2)%4] ^ f3[(r+3)%4];
            end
        end
        return t;
    endfunction

endpackage

// ===== hdl/aesbcm_if.sv =====
// Handshake channel interfaces of the AES modes core: input words, result words, config writes.
// Depends on nothing; the payload widths follow the block's field list.
interface aesbcm_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    modport source (output valid, req_type, data_hi, data_lo, input ready);
    modport sink (input valid, req_type, data_hi, data_lo, output ready);
endinterface

interface aesbcm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink (input valid, result_hi, result_lo, output ready);
endinterface

interface aesbcm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/aesbcm_front.sv =====
// Front end: accepts input words, classifies them by mode and queues them for the back end.
// Depends on aesbcm_pkg and aesbcm_in_if.
module aesbcm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           mode,
    aesbcm_in_if.sink            din,
    output aesbcm_pkg::q_entry_t q_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output logic [1:0]           q_count
);
    import aesbcm_pkg::*;

    q_entry_t   q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       acc;
    logic       push;
    q_entry_t   ent;

    assign din.ready = (cnt_reg != 2'd2);
    assign acc       = din.valid && din.ready;

    // data words in an unused mode produce nothing and are dropped here
    always_comb
    begin
        ent.data = {din.data_hi, din.data_lo};
        push     = acc;
        if (din.req_type != REQ_DATA)
        begin
            ent.op = (mode == MODE_CTR) ? OP_CTR_RST : OP_LOAD_IV;
        end
        else
        begin
            ent.op = OP_DATA;
            push   = acc && (mode <= MODE_CTR);
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= ent;
        end
    end

    assign q_data  = q_reg[rd_ptr_reg];
    assign q_valid = (cnt_reg != 2'd0);
    assign q_count = cnt_reg;

endmodule

// ===== hdl/aesbcm_core.sv =====
// Back end: key expansion into the round key memory, one AES round per cycle, chaining modes.
// Depends on aesbcm_pkg and aesbcm_out_if.
module aesbcm_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aesbcm_pkg::cfg_t       cfg,
    input  logic                   key_change,
    input  aesbcm_pkg::q_entry_t   q_data,
    input  logic                   q_valid,
    output logic                   q_pop,
    aesbcm_out_if.source           dout,
    output aesbcm_pkg::core_stat_t stat
);
    import aesbcm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXPAND = 5'b00010,
        S_PREP   = 5'b00100,
        S_ROUND  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [BLOCK_W-1:0] rk_mem [RK_ROWS];
    logic [BLOCK_W-1:0] rk_reg;
    logic [BLOCK_W-1:0] st_reg, st_next;
    logic [BLOCK_W-1:0] d_reg, d_next;
    logic [BLOCK_W-1:0] chain_reg, chain_next;
    logic [63:0]        ctr_reg, ctr_next;
    logic               kr_reg, kr_next;
    logic [3:0]         rnd_reg, rnd_next;
    logic [5:0]         i_reg, i_next;
    logic [2:0]         m_reg, m_next;
    logic [7:0]         rc_reg, rc_next;
    logic [31:0]        win_reg [8];
    logic [95:0]        row_reg;
    logic               ov_reg, ov_next;
    logic [BLOCK_W-1:0] res_reg, res_next;

    logic [3:0]         nr, nk;
    logic [5:0]         last_word;
    logic               dec;
    logic [3:0]         addr;
    logic [31:0]        w, t_word, kw;
    logic               wr_row;
    logic               out_free;
    logic [BLOCK_W-1:0] rnd_out, e_sr, e_mx, d_sb, d_ak;
    logic [4:0]         seg;
    logic [BLOCK_W-1:0] fb_src;
    logic [7:0]         sh_lo, sh_hi;

    always_comb
    begin
        case (cfg.key_size)
            KSZ_128: begin nr = NR_128; nk = NK_128; end
            KSZ_192: begin nr = NR_192; nk = NK_192; end
            default: begin nr = NR_256; nk = NK_256; end
        endcase
        last_word = {nr, 2'b11};
        dec = (cfg.mode == MODE_ECB_DEC) || (cfg.mode == MODE_CBC_DEC);
    end

    // ---- key expansion: one word per cycle, written a row of four at a time
    always_comb
    begin
        kw     = cfg.key[KEY_W-1-32*i_reg[2:0] -: 32];
        t_word = win_reg[0];
        if (m_reg == 3'd0)
        begin
            t_word = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rc_reg, 24'h0};
        end
        else if ((nk == NK_256) && (m_reg == 3'd4))
        begin
            t_word = sub_word(win_reg[0]);
        end
        w      = ({2'b00, i_reg} < {4'd0, nk}) ? kw : (win_reg[nk[2:0] - 3'd1] ^ t_word);
        wr_row = (state_reg == S_EXPAND) && (i_reg[1:0] == 2'b11);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXPAND)
        begin
            win_reg[0] <= w;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            row_reg <= {row_reg[63:0], w};
        end
        if (wr_row)
        begin
            rk_mem[i_reg[5:2]] <= {row_reg, w};
        end
        rk_reg <= rk_mem[addr];
    end

    // ---- round datapath
    always_comb
    begin
        e_sr    = shift_rows(sub_bytes(st_reg, 1'b0), 1'b0);
        e_mx    = (rnd_reg == nr) ? e_sr : mix_columns(e_sr, 1'b0);
        d_sb    = sub_bytes(shift_rows(st_reg, 1'b1), 1'b1);
        d_ak    = d_sb ^ rk_reg;
        if (rnd_reg == 4'd0)
        begin
            rnd_out = st_reg ^ rk_reg;
        end
        else if (dec)
        begin
            rnd_out = (rnd_reg == nr) ? d_ak : mix_columns(d_ak, 1'b1);
        end
        else
        begin
            rnd_out = e_mx ^ rk_reg;
        end
    end

    // ---- CFB feedback amount
    always_comb
    begin
        seg = cfg.segment;
        if (seg == 5'd0)
        begin
            seg = 5'd1;
        end
        else if (seg > 5'd16)
        begin
            seg = 5'd16;
        end
        sh_lo  = {seg, 3'b000};
        sh_hi  = 8'd128 - sh_lo;
        fb_src = (cfg.mode == MODE_CFB_ENC) ? (d_reg ^ st_reg) : d_reg;
    end

    assign out_free = !ov_reg || dout.ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // ---- sequencer
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        d_next     = d_reg;
        chain_next = chain_reg;
        ctr_next   = ctr_reg;
        kr_next    = kr_reg && !key_change;
        rnd_next   = rnd_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        rc_next    = rc_reg;
        ov_next    = ov_reg && !dout.ready;
        res_next   = res_reg;
        addr       = 4'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_data.op)
                        OP_LOAD_IV: chain_next = q_data.data;
                        OP_CTR_RST: ctr_next = 64'd0;
                        default:
                        begin
                            d_next = q_data.data;
                            case (cfg.mode)
                                MODE_CBC_ENC: st_next = q_data.data ^ chain_reg;
                                MODE_CFB_ENC, MODE_CFB_DEC,
                                MODE_OFB_ENC, MODE_OFB_DEC: st_next = chain_reg;
                                MODE_CTR: st_next = {NONCE_HI, ctr_reg};
                                default: st_next = q_data.data;
                            endcase
                            i_next     = 6'd0;
                            m_next     = 3'd0;
                            rc_next    = 8'h01;
                            state_next = kr_reg ? S_PREP : S_EXPAND;
                        end
                    endcase
                end
            end
            S_EXPAND:
            begin
                i_next = i_reg + 6'd1;
                m_next = (m_reg == nk[2:0] - 3'd1) ? 3'd0 : m_reg + 3'd1;
                if ((m_reg == 3'd0) && ({2'b00, i_reg} >= {4'd0, nk}))
                begin
                    rc_next = xt(rc_reg);
                end
                if (i_reg == last_word)
                begin
                    kr_next    = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                addr       = dec ? nr : 4'd0;
                rnd_next   = 4'd0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                addr     = dec ? (nr - rnd_reg - 4'd1) : (rnd_reg + 4'd1);
                st_next  = rnd_out;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == nr)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                    case (cfg.mode)
                        MODE_ECB_ENC, MODE_ECB_DEC: res_next = st_reg;
                        MODE_CBC_ENC:
                        begin
                            res_next   = st_reg;
                            chain_next = st_reg;
                        end
                        MODE_CBC_DEC:
                        begin
                            res_next   = st_reg ^ chain_reg;
                            chain_next = d_reg;
                        end
                        MODE_CFB_ENC, MODE_CFB_DEC:
                        begin
                            res_next   = d_reg ^ st_reg;
                            chain_next = (chain_reg << sh_lo) | (fb_src >> sh_hi);
                        end
                        MODE_OFB_ENC, MODE_OFB_DEC:
                        begin
                            res_next   = d_reg ^ st_reg;
                            chain_next = st_reg;
                        end
                        default:
                        begin
                            res_next = d_reg ^ st_reg;
                            ctr_next = ctr_reg + 64'd1;
                        end
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chain_reg <= '0;
            ctr_reg   <= '0;
            kr_reg    <= 1'b0;
            rnd_reg   <= 4'd0;
            i_reg     <= 6'd0;
            m_reg     <= 3'd0;
            rc_reg    <= 8'h01;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            ctr_reg   <= ctr_next;
            kr_reg    <= kr_next;
            rnd_reg   <= rnd_next;
            i_reg     <= i_next;
            m_reg     <= m_next;
            rc_reg    <= rc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        d_reg   <= d_next;
        res_reg <= res_next;
    end

    assign dout.valid     = ov_reg;
    assign dout.result_hi = res_reg[BLOCK_W-1:64];
    assign dout.result_lo = res_reg[63:0];

    assign stat.in_round   = (state_reg == S_ROUND);
    assign stat.keys_ready = kr_reg;
    assign stat.rnd        = rnd_reg;
    assign stat.nr         = nr;

endmodule

// ===== hdl/aes_block_cipher_modes_core.sv =====
// Top level of the AES modes core: config registers, front end, back end, checks.
// Depends on aesbcm_pkg, aesbcm_if, aesbcm_front and aesbcm_core.
//
// Usage
//   cfg  : register writes (index, 64-bit data), always ready. 0 key size, 1 mode,
//          2 CFB segment in bytes, 3..6 key bytes 0-31. Write only while the core is idle.
//   din  : one word per block. req_type 1 loads the IV (or restarts the counter in CTR
//          mode) and gives no result; req_type 0 is a data block and gives one result.
//   dout : one result word per data block, in order.
// Processing
//   A data block leaves the queue and passes the prep state, the rounds and the finish
//   state on its way to the result register; the single round unit does one round per
//   cycle. The first block after a key change first has the key schedule written into
//   the round key memory, one word per cycle. IV loads and counter restarts are taken
//   in the idle state and give no result. Blocks are processed one at a time since the
//   chaining modes need the previous block's result.
// Reset and stall
//   Reset clears the config registers (segment 16), chaining value, counter and the
//   key-valid flag; the round key memory is rewritten before first use. A stalled
//   receiver holds the result register; the two-entry input queue keeps taking words
//   until full, and the round unit waits with its finished block.
module aes_block_cipher_modes_core (
    input logic          clk,
    input logic          rst_n,
    aesbcm_cfg_if.sink   cfg,
    aesbcm_in_if.sink    din,
    aesbcm_out_if.source dout
);
    import aesbcm_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic       key_change;
    q_entry_t   q_data;
    logic       q_valid;
    logic       q_pop;
    logic [1:0] q_count;
    core_stat_t stat;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // key size or key word writes invalidate the expanded schedule
    assign key_change = cfg_wr && ((cfg.index == CFG_KEY_SIZE) ||
                        ((cfg.index >= CFG_KEY_W0) && (cfg.index <= CFG_KEY_W3)));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg.index)
                CFG_KEY_SIZE: cfg_next.key_size = cfg.data[1:0];
                CFG_MODE:     cfg_next.mode = cfg.data[3:0];
                CFG_SEGMENT:  cfg_next.segment = cfg.data[4:0];
                default:
                begin
                    if (cfg.index inside {[CFG_KEY_W0:CFG_KEY_W3]})
                    begin
                        cfg_next.key[KEY_W-1-64*(cfg.index - CFG_KEY_W0) -: 64] = cfg.data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{key_size: KSZ_128, mode: MODE_ECB_ENC, segment: 5'd16, key: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    aesbcm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (cfg_reg.mode),
        .din     (din),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_count (q_count)
    );

    aesbcm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .key_change (key_change),
        .q_data     (q_data),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .dout       (dout),
        .stat       (stat)
    );

`ifndef SYNTH
    // rounds never run on a stale key schedule
    a_keys_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_round |-> stat.keys_ready)
        else $error("round started without expanded keys");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_round |-> (stat.rnd <= stat.nr))
        else $error("round counter past last round");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 2'd2)
        else $error("input queue overflow");

    a_round_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.in_round && (stat.rnd != stat.nr)) |=>
            (stat.in_round && (stat.rnd == $past(stat.rnd) + 4'd1)))
        else $error("round sequence broken");
`endif

endmodule
